>>> rtl/ufr_pkg.sv
// Package with the types, codes and constants shared by the UART frame receiver.
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int unsigned MAX_FRAME_DEF = 1024;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned TOTAL_W  = 11;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TOTAL_W-1:0] FRAME_LIMIT_RST = 11'd1024;
  localparam logic [BYTE_W-1:0]  START_FLAG_RST  = 8'd0;

  // Frame bytes outside the payload: flag, type, two length bytes, checksum.
  localparam logic [LEN_W:0] HDR_TRL_BYTES = 17'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_FLAG  = 1'b0,
    CFG_FRAME_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_LEN   = 2'd2,
    ST_FAULT = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              link_fault;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [INDEX_W-1:0] payload_index;
    logic               frame_end;
    logic [1:0]         frame_status;
    logic [TOTAL_W-1:0] total_length;
  } out_item_t;

endpackage

>>> rtl/uart_frame_receiver.sv
// UART frame receiver: start flag, type, length, payload and additive checksum.
`timescale 1ns / 1ps

// The block takes one received byte per request and can accept a request in every
// clock cycle; the only thing that holds it back is a result waiting in the output
// register while out_ready is low, since a new request is then taken only if that
// result leaves in the same cycle. A result appears in the cycle after the byte that
// causes it. Bytes are dropped until one equals the start flag; the type byte and a
// little-endian 16-bit length follow. A frame longer than frame_limit or MAX_FRAME
// bytes in total ends at once with a length error. Each payload byte is passed on
// with its index, and the checksum byte, compared against the 8-bit sum of all
// earlier frame bytes, ends the frame with an ok or checksum-error status. A link
// fault ends a frame in progress with its own status and is ignored while hunting.
// Configuration writes take effect on the next cycle and should be made while idle.
module uart_frame_receiver
  import ufr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME);

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_KIND   = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_LEN_HI = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CHECK  = 6'b100000
  } phase_t;

  logic [BYTE_W-1:0]  start_flag_r;
  logic [TOTAL_W-1:0] frame_limit_r;

  phase_t             phase_r,   phase_nxt;
  logic [BYTE_W-1:0]  kind_r,    kind_nxt;
  logic [LEN_W-1:0]   plen_r,    plen_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [BYTE_W-1:0]  sum_r,     sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  logic               in_fire;
  logic               emit;
  out_item_t          result;
  logic [LEN_W-1:0]   len_full;
  logic [LEN_W:0]     total;
  logic [CNT_W:0]     count_inc;
  logic [BYTE_W-1:0]  sum_add;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sum_add   = sum_r + in_data.rx_byte;
  assign len_full  = {in_data.rx_byte, plen_r[BYTE_W-1:0]};
  assign total     = {1'b0, len_full} + HDR_TRL_BYTES;
  assign count_inc = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    plen_nxt  = plen_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    result.frame_kind    = kind_r;
    result.payload_byte  = '0;
    result.payload_index = '0;
    result.frame_end     = 1'b1;
    result.frame_status  = ST_OK;
    result.total_length  = '0;
    if (in_data.link_fault) begin
      if (phase_r != PH_HUNT) begin
        emit                = 1'b1;
        result.frame_status = ST_FAULT;
        phase_nxt           = PH_HUNT;
      end
    end else begin
      case (phase_r)
        PH_KIND: begin
          kind_nxt  = in_data.rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          plen_nxt  = {{(LEN_W-BYTE_W){1'b0}}, in_data.rx_byte};
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          plen_nxt = len_full;
          sum_nxt  = sum_add;
          if (total > (LEN_W+1)'(MAX_FRAME) ||
              total > {{(LEN_W+1-TOTAL_W){1'b0}}, frame_limit_r}) begin
            emit                = 1'b1;
            result.frame_status = ST_LEN;
            phase_nxt           = PH_HUNT;
          end else begin
            count_nxt = '0;
            phase_nxt = (len_full == '0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          emit                 = 1'b1;
          result.payload_byte  = in_data.rx_byte;
          result.payload_index = INDEX_W'(count_r);
          result.frame_end     = 1'b0;
          sum_nxt              = sum_add;
          count_nxt            = count_inc[CNT_W-1:0];
          if ((LEN_W+1)'(count_inc) >= {1'b0, plen_r}) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          emit = 1'b1;
          if (in_data.rx_byte == sum_r) begin
            result.total_length = TOTAL_W'({1'b0, plen_r} + HDR_TRL_BYTES);
          end else begin
            result.frame_status = ST_CSUM;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          if (in_data.rx_byte == start_flag_r) begin
            kind_nxt  = '0;
            plen_nxt  = '0;
            count_nxt = '0;
            sum_nxt   = in_data.rx_byte;
            phase_nxt = PH_KIND;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r  <= START_FLAG_RST;
      frame_limit_r <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_FLAG:  start_flag_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_FRAME_LIMIT: frame_limit_r <= cfg_wdata[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      kind_r      <= '0;
      plen_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        plen_r  <= plen_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // A payload result never carries an end status or a length.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.frame_end |->
      out_data_r.frame_status == ST_OK && out_data_r.total_length == '0)
    else $error("payload result with end fields set");

  // A payload byte always yields a result in the next cycle.
  a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_DATA && !in_data.link_fault |=>
      out_valid_r && !out_data_r.frame_end)
    else $error("payload byte without result");

  // The checksum byte always closes the frame and returns to hunting.
  a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_CHECK |=>
      out_valid_r && out_data_r.frame_end && phase_r == PH_HUNT)
    else $error("checksum byte did not end the frame");

endmodule

>>> dv/uart_frame_receiver_tb.sv
// Self-checking testbench for the UART frame receiver with a predicting scoreboard.
`timescale 1ns / 1ps

module uart_frame_receiver_tb;
  import ufr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP    = 30;

  typedef enum logic [2:0] {
    RX_HUNT,
    RX_KIND,
    RX_LEN_LO,
    RX_LEN_HI,
    RX_DATA,
    RX_CHECK
  } rx_phase_t;

  class frame_checker;
    out_item_t        awaited_results[$];
    logic [7:0]       start_flag;
    logic [CFG_W-1:0] frame_limit;
    rx_phase_t        phase;
    logic [7:0]       kind;
    logic [LEN_W-1:0] payload_len;
    logic [LEN_W-1:0] byte_count;
    logic [7:0]       sum;
    int unsigned      mismatches, requests, data_bytes;
    int unsigned      ok_frames, csum_errors, len_errors, faults;

    function new();
      start_flag  = START_FLAG_RST;
      frame_limit = FRAME_LIMIT_RST;
      phase       = RX_HUNT;
      kind        = '0;
      payload_len = '0;
      byte_count  = '0;
      sum         = '0;
    endfunction

    function void configure(logic [7:0] flag, logic [CFG_W-1:0] limit);
      start_flag  = flag;
      frame_limit = limit;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void note_request(in_item_t req);
      out_item_t        res;
      logic [LEN_W:0]   total;
      bit               produced;
      logic [7:0]       b;
      res      = '0;
      produced = 1'b0;
      b        = req.rx_byte;
      requests++;
      if (req.link_fault) begin
        if (phase != RX_HUNT) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_FAULT;
          produced         = 1'b1;
          phase            = RX_HUNT;
        end
      end else begin
        case (phase)
          RX_KIND: begin
            kind  = b;
            sum   = sum + b;
            phase = RX_LEN_LO;
          end
          RX_LEN_LO: begin
            payload_len = {8'h00, b};
            sum         = sum + b;
            phase       = RX_LEN_HI;
          end
          RX_LEN_HI: begin
            payload_len[15:8] = b;
            sum   = sum + b;
            total = {1'b0, payload_len} + HDR_TRL_BYTES;
            if (total > MAX_FRAME_DEF || total > frame_limit) begin
              res.frame_end    = 1'b1;
              res.frame_status = ST_LEN;
              produced         = 1'b1;
              phase            = RX_HUNT;
            end else begin
              byte_count = '0;
              phase      = (payload_len == 0) ? RX_CHECK : RX_DATA;
            end
          end
          RX_DATA: begin
            res.payload_byte  = b;
            res.payload_index = byte_count[INDEX_W-1:0];
            produced          = 1'b1;
            sum               = sum + b;
            byte_count        = byte_count + 1'b1;
            if (byte_count >= payload_len) phase = RX_CHECK;
          end
          RX_CHECK: begin
            res.frame_end = 1'b1;
            produced      = 1'b1;
            if (b == sum) begin
              total            = {1'b0, payload_len} + HDR_TRL_BYTES;
              res.frame_status = ST_OK;
              res.total_length = total[TOTAL_W-1:0];
            end else begin
              res.frame_status = ST_CSUM;
            end
            phase = RX_HUNT;
          end
          default: begin
            if (b == start_flag) begin
              kind        = '0;
              payload_len = '0;
              byte_count  = '0;
              sum         = b;
              phase       = RX_KIND;
            end
          end
        endcase
      end
      res.frame_kind = kind;
      if (produced) awaited_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h arrived with nothing awaited", got));
        return;
      end
      want = awaited_results.pop_front();
      check_field("frame_kind", got.frame_kind, want.frame_kind);
      check_field("payload_byte", got.payload_byte, want.payload_byte);
      check_field("payload_index", got.payload_index, want.payload_index);
      check_field("frame_end", got.frame_end, want.frame_end);
      check_field("frame_status", got.frame_status, want.frame_status);
      check_field("total_length", got.total_length, want.total_length);
      if (!want.frame_end) begin
        data_bytes++;
      end else begin
        case (want.frame_status)
          ST_OK:   ok_frames++;
          ST_CSUM: csum_errors++;
          ST_LEN:  len_errors++;
          default: faults++;
        endcase
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START_FLAG;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  frame_checker     sb;
  in_item_t         stim_q[$];
  logic [7:0]       flag_now  = START_FLAG_RST;
  int               limit_now = int'(FRAME_LIMIT_RST);
  int unsigned      idle_pct  = 0;
  int unsigned      stall_pct = 0;
  int unsigned      cycle_count = 0;
  int unsigned      settings_run = 1;

  uart_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run timed out with %0d results still awaited.", sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic in_item_t byte_req(logic [7:0] b);
    in_item_t req;
    req.rx_byte    = b;
    req.link_fault = 1'b0;
    return req;
  endfunction

  function automatic in_item_t fault_req();
    in_item_t req;
    req.rx_byte    = 8'($urandom);
    req.link_fault = 1'b1;
    return req;
  endfunction

  function automatic int accepted_max_len();
    int eff;
    eff = (limit_now < int'(MAX_FRAME_DEF)) ? limit_now : int'(MAX_FRAME_DEF);
    return eff - 5;
  endfunction

  // A frame that fails the length check is sent as its header only.
  function automatic void add_frame(logic [7:0] kind, int len, bit bad_sum, int fault_at);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    frame_q.push_back(flag_now);
    frame_q.push_back(kind);
    frame_q.push_back(8'(len));
    frame_q.push_back(8'(len >> 8));
    if (len <= accepted_max_len()) begin
      for (int k = 0; k < len; k++) frame_q.push_back(8'($urandom));
      sum = '0;
      foreach (frame_q[k]) sum = sum + frame_q[k];
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      frame_q.push_back(sum);
    end
    foreach (frame_q[k]) begin
      if (k == fault_at) begin
        stim_q.push_back(fault_req());
        return;
      end
      stim_q.push_back(byte_req(frame_q[k]));
    end
  endfunction

  function automatic void add_noise(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 12) stim_q.push_back(fault_req());
      else stim_q.push_back(byte_req(8'($urandom)));
    end
  endfunction

  function automatic void add_traffic(int unsigned count);
    int unsigned target;
    int          max_len, len, pick, fault_at;
    target  = stim_q.size() + count;
    max_len = accepted_max_len();
    while (stim_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        add_noise($urandom_range(1, 4));
      end else begin
        pick = $urandom_range(99);
        if (max_len < 0) begin
          len = $urandom_range(0, 65535);
        end else if (pick < 12) begin
          if ($urandom_range(1)) len = max_len + 1 + $urandom_range(0, 2);
          else len = $urandom_range(max_len + 1, 65535);
        end else if (pick < 20) begin
          len = (max_len <= 40) ? max_len : $urandom_range(17, 80);
        end else begin
          len = $urandom_range(0, (max_len < 12) ? max_len : 12);
        end
        fault_at = ($urandom_range(99) < 8) ? $urandom_range(1, len + 4) : -1;
        add_frame(8'($urandom), len, $urandom_range(99) < 12, fault_at);
      end
    end
  endfunction

  task automatic drive_requests(int pause_at);
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= stim_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_request(stim_q[i]);
    end
    in_valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] flag, logic [CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_FLAG;
    cfg_wdata <= CFG_W'(flag);
    @(posedge clk);
    cfg_index <= CFG_FRAME_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    flag_now  = flag;
    limit_now = int'(limit);
    sb.configure(flag, limit);
    settings_run++;
  endtask

  task automatic run_phase(logic [7:0] flag, logic [CFG_W-1:0] limit,
                           int unsigned idle, int unsigned stall, int unsigned count);
    write_config(flag, limit);
    idle_pct  = idle;
    stall_pct = stall;
    add_traffic(count);
    drive_requests(-1);
    settle();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the start flag is zero, so zero-valued type and length bytes
    // also exercise the flag appearing inside a frame.
    stim_q.push_back(fault_req());
    add_frame(8'h00, 0, 1'b0, -1);
    add_frame(8'hFF, 2, 1'b1, -1);
    add_frame(8'h12, 3, 1'b0, 2);
    add_frame(8'hA5, 16'hFFFF, 1'b0, -1);
    add_frame(8'h5A, 1, 1'b0, -1);
    add_traffic(80);
    add_traffic(40);
    drive_requests(60);
    settle();

    run_phase(8'h7E, 11'd1024, 65, 0, 80);
    run_phase(8'hFF, 11'd5, 0, 65, 70);
    run_phase(8'($urandom), 11'd4, 33, 33, 50);
    run_phase(8'h55, 11'd2047, 33, 33, 70);
    run_phase(8'($urandom), CFG_W'($urandom_range(5, 1024)), 0, 65, 70);

    $display("Run covered %0d requests under %0d register settings.",
             sb.requests, settings_run);
    $display("Results seen: %0d payload bytes, %0d ok, %0d checksum, %0d length, %0d fault ends.",
             sb.data_bytes, sb.ok_frames, sb.csum_errors, sb.len_errors, sb.faults);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
